>>> hw/rtl/atsk_pkg.sv
// Shared types and constants for the affine texture span sampler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package atsk_pkg;

  // Field widths
  localparam int unsigned KindW    = 2;
  localparam int unsigned AddrW    = 14;
  localparam int unsigned ColourW  = 8;
  localparam int unsigned XW       = 11;
  localparam int unsigned CoordInW = 23;   // 7.16 coordinate as it arrives
  localparam int unsigned PosW     = 24;   // position and increment registers
  localparam int unsigned CntW     = 12;   // pixel count, up to 2048
  localparam int unsigned SpanW    = 13;   // signed end - start + 1
  localparam int unsigned TexColW  = 7;    // integer texel coordinate bits
  localparam int unsigned TexWidth = 128;

  // Divider: magnitude of a delta fits in 23 bits, one quotient bit a cycle
  localparam int unsigned MagW     = 23;
  localparam int unsigned DivCntW  = 5;
  localparam logic [DivCntW-1:0] DivSteps = 5'd23;

  localparam logic [ColourW-1:0] MaskColour = 8'd255;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_U,
    ST_DIV_V,
    ST_READ
  } state_e;

  // Sequencer to divider
  typedef struct packed {
    logic                   start;
    logic signed [PosW-1:0] dividend;
    logic [CntW-1:0]        divisor;
  } div_req_t;

  // Divider to sequencer
  typedef struct packed {
    logic            done;
    logic [PosW-1:0] quotient;
  } div_rsp_t;

  // Texture store write port
  typedef struct packed {
    logic               en;
    logic [AddrW-1:0]   addr;
    logic [ColourW-1:0] data;
  } tex_wr_t;

  // Texture store read port
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } tex_rd_t;

endpackage : atsk_pkg

`default_nettype wire

>>> hw/rtl/atsk_req_if.sv
// Request channel of the span sampler: valid/ready plus the request fields.
// Depends on atsk_pkg for the field widths.
`default_nettype none

interface atsk_req_if
  import atsk_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [AddrW-1:0]    texel_address;
  logic [ColourW-1:0]  texel_value;
  logic [XW-1:0]       span_start_x;
  logic [XW-1:0]       span_end_x;
  logic [CoordInW-1:0] u_start;
  logic [CoordInW-1:0] v_start;
  logic [CoordInW-1:0] u_end;
  logic [CoordInW-1:0] v_end;

  modport source (
    output valid, kind, texel_address, texel_value, span_start_x, span_end_x,
           u_start, v_start, u_end, v_end,
    input  ready
  );

  modport sink (
    input  valid, kind, texel_address, texel_value, span_start_x, span_end_x,
           u_start, v_start, u_end, v_end,
    output ready
  );
endinterface : atsk_req_if

`default_nettype wire

>>> hw/rtl/atsk_pix_if.sv
// Pixel result channel of the span sampler: valid/ready plus pixel fields.
// Depends on atsk_pkg for the field widths.
`default_nettype none

interface atsk_pix_if
  import atsk_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [XW-1:0]      screen_x;
  logic [ColourW-1:0] pixel_colour;
  logic               write_enable;
  logic               last_pixel;

  modport source (
    output valid, screen_x, pixel_colour, write_enable, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, screen_x, pixel_colour, write_enable, last_pixel,
    output ready
  );
endinterface : atsk_pix_if

`default_nettype wire

>>> hw/rtl/atsk_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on atsk_pkg for the request/response structs and widths.
`default_nettype none

module atsk_div
  import atsk_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic [MagW-1:0]     mag_q, mag_d;      // dividend bits out, quotient bits in
  logic [CntW-1:0]     rem_q, rem_d;
  logic [CntW-1:0]     dsr_q, dsr_d;

  logic [CntW:0]       trial;
  logic                fits;
  logic [PosW-1:0]     abs_dividend;

  // magnitude of the dividend; |delta| stays below 2^23
  assign abs_dividend = req_i.dividend[PosW-1] ? (PosW'(0) - req_i.dividend)
                                               : req_i.dividend;

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, mag_q[MagW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivSteps;
      neg_d  = req_i.dividend[PosW-1];
      mag_d  = abs_dividend[MagW-1:0];
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? CntW'(trial - {1'b0, dsr_q}) : trial[CntW-1:0];
      mag_d = {mag_q[MagW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  // apply the sign to the magnitude quotient
  always_comb begin
    rsp_o.done     = done_q;
    rsp_o.quotient = neg_q ? (PosW'(0) - {1'b0, mag_q}) : {1'b0, mag_q};
  end

endmodule : atsk_div

`default_nettype wire

>>> hw/rtl/atsk_tex_store.sv
// Texture store: TexWidth x TEX_ROWS palette indices, one write and one
// registered read port. Depends on atsk_pkg for the port structs.
`default_nettype none

module atsk_tex_store
  import atsk_pkg::*;
#(
  parameter int unsigned TEX_ROWS = 128
) (
  input  wire logic    clk_i,
  input  wire tex_wr_t wr_i,
  input  wire tex_rd_t rd_i,
  output logic [ColourW-1:0] rd_data_o
);

  localparam int unsigned Depth  = TexWidth * TEX_ROWS;
  localparam int unsigned Aw     = $clog2(Depth);
  localparam int unsigned Rw     = (Aw > AddrW) ? Aw : AddrW;
  // number of conditional subtractions to bring a 14-bit index below Depth
  localparam int unsigned RedSteps = $clog2((1 << AddrW) / Depth + 1);

  logic [ColourW-1:0] mem_q [Depth];
  logic [ColourW-1:0] rd_data_q;
  logic [Aw-1:0]      wr_idx;
  logic [Aw-1:0]      rd_idx;

  // index modulo the store size, by a short chain of constant subtractions
  function automatic logic [Aw-1:0] reduce(input logic [AddrW-1:0] a);
    logic [Rw-1:0] r;
    r = Rw'(a);
    for (int k = RedSteps - 1; k >= 0; k--) begin
      if (32'(r) >= (Depth << k)) begin
        r = r - Rw'(Depth << k);
      end
    end
    return r[Aw-1:0];
  endfunction

  assign wr_idx = reduce(wr_i.addr);
  assign rd_idx = reduce(rd_i.addr);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : atsk_tex_store

`default_nettype wire

>>> hw/rtl/affine_texture_span_keyed.sv
// Top level of the affine texture span sampler: request decode, sequencer,
// span registers and pixel output register. Uses atsk_pkg, both channel
// interfaces, atsk_div and atsk_tex_store.
`default_nettype none

// Requests arrive on req_i and pixels leave on pix_o. A texel write is
// done in the idle state. A step request is taken in idle and then moves
// to the read state for the registered read of the texture store; its
// pixel then sits in the output register, and the next request is taken
// while that pixel waits. A step that finds the output register still full
// holds in its read cycle until the pixel there is taken. A start request
// with an empty span stays in idle; any other start runs the u and v
// increments one after the other through a single serial divider that
// yields one quotient bit per cycle, and takes no request until both are
// done. The texture store is not cleared at reset; a texel must be written
// before it is sampled. Step requests with no pixels left in the span, and
// unused request kinds, produce nothing.
module affine_texture_span_keyed
  import atsk_pkg::*;
#(
  parameter int unsigned TEX_ROWS = 128,
  parameter int unsigned MAX_SPAN = 2048
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  atsk_req_if.sink  req_i,
  atsk_pix_if.source pix_o
);

  localparam logic [SpanW-1:0] MaxSpanC = SpanW'(MAX_SPAN);

  state_e state_q, state_d;

  // span state
  logic [CntW-1:0] pixels_left_q;
  logic [XW-1:0]   x_q;
  logic [PosW-1:0] u_pos_q, v_pos_q;
  logic [PosW-1:0] u_inc_q, v_inc_q;

  // held for the second division and for the pending pixel
  logic signed [PosW-1:0] delta_v_q;
  logic [CntW-1:0]        count_q;
  logic [XW-1:0]          pend_x_q;
  logic                   pend_last_q;

  // output register
  logic               out_valid_q;
  logic [XW-1:0]      out_x_q;
  logic [ColourW-1:0] out_colour_q;
  logic               out_last_q;

  logic                   accept;
  logic                   is_write, is_start, is_step;
  logic [SpanW-1:0]       span_raw;
  logic                   span_ok;
  logic [CntW-1:0]        span_count;
  logic signed [PosW-1:0] delta_u, delta_v;
  logic                   out_free;
  logic                   out_load;
  logic [ColourW-1:0]     rd_colour;

  div_req_t div_req;
  div_rsp_t div_rsp;
  tex_wr_t  tex_wr;
  tex_rd_t  tex_rd;

  // request decode
  assign accept   = req_i.valid && req_i.ready;
  assign is_write = (req_i.kind == KIND_WRITE);
  assign is_start = (req_i.kind == KIND_START);
  assign is_step  = (req_i.kind == KIND_STEP) && (pixels_left_q != '0);

  // span length, empty when not positive, clipped at MAX_SPAN
  assign span_raw   = {2'b00, req_i.span_end_x} - {2'b00, req_i.span_start_x}
                      + SpanW'(1);
  assign span_ok    = !span_raw[SpanW-1] && (span_raw != '0);
  assign span_count = (span_raw > MaxSpanC) ? MaxSpanC[CntW-1:0]
                                            : span_raw[CntW-1:0];

  assign delta_u = {1'b0, req_i.u_end} - {1'b0, req_i.u_start};
  assign delta_v = {1'b0, req_i.v_end} - {1'b0, req_i.v_start};

  assign out_free = !out_valid_q || pix_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_start && span_ok) begin
          state_d = ST_DIV_U;
        end else if (accept && is_step) begin
          state_d = ST_READ;
        end
      end
      ST_DIV_U: if (div_rsp.done) state_d = ST_DIV_V;
      ST_DIV_V: if (div_rsp.done) state_d = ST_IDLE;
      ST_READ:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_i.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = delta_u;
    div_req.divisor  = span_count;
    tex_wr.en        = 1'b0;
    tex_wr.addr      = req_i.texel_address;
    tex_wr.data      = req_i.texel_value;
    tex_rd.en        = 1'b0;
    tex_rd.addr      = {v_pos_q[16 +: TexColW], u_pos_q[16 +: TexColW]};
    out_load         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready   = 1'b1;
        div_req.start = accept && is_start && span_ok;
        tex_wr.en     = accept && is_write;
        tex_rd.en     = accept && is_step;
      end
      ST_DIV_U: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = delta_v_q;
        div_req.divisor  = count_q;
      end
      ST_DIV_V: ;
      ST_READ:  out_load = out_free;
      default: ;
    endcase
  end

  // span control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pixels_left_q <= '0;
      x_q           <= '0;
      u_pos_q       <= '0;
      v_pos_q       <= '0;
      u_inc_q       <= '0;
      v_inc_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && accept && is_start) begin
        x_q           <= req_i.span_start_x;
        u_pos_q       <= {1'b0, req_i.u_start};
        v_pos_q       <= {1'b0, req_i.v_start};
        pixels_left_q <= span_ok ? span_count : '0;
        u_inc_q       <= '0;
        v_inc_q       <= '0;
      end else if (state_q == ST_IDLE && accept && is_step) begin
        // the read address was taken from the old positions this cycle
        u_pos_q       <= u_pos_q + u_inc_q;
        v_pos_q       <= v_pos_q + v_inc_q;
        x_q           <= x_q + XW'(1);
        pixels_left_q <= pixels_left_q - CntW'(1);
      end
      if (state_q == ST_DIV_U && div_rsp.done) u_inc_q <= div_rsp.quotient;
      if (state_q == ST_DIV_V && div_rsp.done) v_inc_q <= div_rsp.quotient;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept && is_start) begin
      delta_v_q <= delta_v;
      count_q   <= span_count;
    end
    if (state_q == ST_IDLE && accept && is_step) begin
      pend_x_q    <= x_q;
      pend_last_q <= (pixels_left_q == CntW'(1));
    end
    if (out_load) begin
      out_x_q      <= pend_x_q;
      out_colour_q <= rd_colour;
      out_last_q   <= pend_last_q;
    end
  end

  atsk_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  atsk_tex_store #(
    .TEX_ROWS (TEX_ROWS)
  ) u_tex_store (
    .clk_i     (clk_i),
    .wr_i      (tex_wr),
    .rd_i      (tex_rd),
    .rd_data_o (rd_colour)
  );

  // pixel channel
  assign pix_o.valid        = out_valid_q;
  assign pix_o.screen_x     = out_x_q;
  assign pix_o.pixel_colour = out_colour_q;
  assign pix_o.write_enable = (out_colour_q != MaskColour);
  assign pix_o.last_pixel   = out_last_q;

`ifndef SYNTH
  // the divider only reports while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_U || state_q == ST_DIV_V))
    else $error("divider result outside a division state");

  // a pixel is only loaded after a store read
  a_pix_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_READ))
    else $error("pixel output loaded without a store read");

  // each pixel taken from a span uses up exactly one count
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_step) |=> (pixels_left_q == $past(pixels_left_q) - CntW'(1)))
    else $error("pixel count did not step by one");
`endif

endmodule : affine_texture_span_keyed

`default_nettype wire

>>> bench/affine_texture_span_keyed_checker.sv
// Pixel checker for the affine texture span sampler: watches both channels,
// predicts each pixel from the accepted requests and compares field by field.
// Depends on atsk_pkg and the atsk_req_if / atsk_pix_if interfaces.
`timescale 1ns / 100ps

module affine_texture_span_keyed_checker
  import atsk_pkg::*;
#(
  parameter int unsigned TEX_ROWS = 128,
  parameter int unsigned MAX_SPAN = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atsk_req_if         req_i,
  atsk_pix_if         pix_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned pixels_o
);

  localparam int unsigned StoreSize = TexWidth * TEX_ROWS;

  typedef struct packed {
    logic [XW-1:0]      screen_x;
    logic [ColourW-1:0] pixel_colour;
    logic               write_enable;
    logic               last_pixel;
  } pixel_t;

  // Shadow of the block's state
  logic [ColourW-1:0] texels [StoreSize];
  logic [CntW-1:0]    span_left;
  logic [XW-1:0]      span_x;
  logic [PosW-1:0]    u_pos, v_pos, u_inc, v_inc;
  pixel_t             expected_pixels [$];

  // Per-pixel increment: signed delta over the count, truncated toward zero
  function automatic logic [PosW-1:0] coord_step(input logic [CoordInW-1:0] from,
                                                 input logic [CoordInW-1:0] to,
                                                 input int count);
    int delta;
    int quotient;
    delta    = int'({1'b0, to}) - int'({1'b0, from});
    quotient = delta / count;
    return quotient[PosW-1:0];
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches_o++;
    end
  endtask

  // Compare accepted pixels first, then fold in the request of this edge
  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_t             want;
    pixel_t             made;
    int                 span_len;
    int                 idx;
    logic [ColourW-1:0] colour;
    if (!rst_ni) begin
      span_left    = '0;
      span_x       = '0;
      u_pos        = '0;
      v_pos        = '0;
      u_inc        = '0;
      v_inc        = '0;
      expected_pixels.delete();
      mismatches_o = 0;
      pending_o    = 0;
      pixels_o     = 0;
    end else begin
      if (pix_i.valid && pix_i.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel at screen_x %0d with none expected", pix_i.screen_x);
          mismatches_o++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("screen_x", want.screen_x, pix_i.screen_x);
          check_field("pixel_colour", want.pixel_colour, pix_i.pixel_colour);
          check_field("write_enable", want.write_enable, pix_i.write_enable);
          check_field("last_pixel", want.last_pixel, pix_i.last_pixel);
          pixels_o++;
        end
      end

      if (req_i.valid && req_i.ready) begin
        case (req_i.kind)
          KIND_WRITE: texels[int'(req_i.texel_address) % StoreSize] = req_i.texel_value;
          KIND_START: begin
            span_len = int'(req_i.span_end_x) - int'(req_i.span_start_x) + 1;
            span_x   = req_i.span_start_x;
            u_pos    = {1'b0, req_i.u_start};
            v_pos    = {1'b0, req_i.v_start};
            if (span_len <= 0) begin
              // empty span: nothing left to draw
              span_left = '0;
              u_inc     = '0;
              v_inc     = '0;
            end else begin
              if (span_len > int'(MAX_SPAN)) span_len = MAX_SPAN;
              span_left = span_len[CntW-1:0];
              u_inc     = coord_step(req_i.u_start, req_i.u_end, span_len);
              v_inc     = coord_step(req_i.v_start, req_i.v_end, span_len);
            end
          end
          KIND_STEP: begin
            if (span_left != '0) begin
              idx = (int'(v_pos[16 +: TexColW]) * TexWidth + int'(u_pos[16 +: TexColW]))
                    % StoreSize;
              colour            = texels[idx];
              made.screen_x     = span_x;
              made.pixel_colour = colour;
              made.write_enable = (colour != MaskColour);
              made.last_pixel   = (span_left == 1);
              expected_pixels.push_back(made);
              u_pos     = u_pos + u_inc;
              v_pos     = v_pos + v_inc;
              span_x    = span_x + 1'b1;
              span_left = span_left - 1'b1;
            end
          end
          default: ;
        endcase
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule : affine_texture_span_keyed_checker

>>> bench/affine_texture_span_keyed_tb.sv
// Top of the span sampler bench: clock, reset, request stimulus, pixel
// back-pressure, watchdog and verdict. Uses atsk_pkg, both channel
// interfaces, the block and affine_texture_span_keyed_checker.
`timescale 1ns / 100ps

module affine_texture_span_keyed_tb;
  import atsk_pkg::*;

  localparam int unsigned TexRows       = 128;
  localparam int unsigned MaxSpan       = 2048;
  localparam int unsigned StoreSize     = TexWidth * TexRows;
  localparam int unsigned RandomItems   = 1100;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 64;
  localparam logic [CoordInW-1:0] CoordMax = '1;
  // Sampled texels stay in two bands of rows and columns, low and high
  localparam int unsigned WinSpan = 8;
  localparam logic [CoordInW-1:0] LoMax = CoordInW'((WinSpan << 16) - 1);
  localparam logic [CoordInW-1:0] HiMin = CoordInW'((TexWidth - WinSpan) << 16);

  typedef struct {
    kind_e               kind;
    logic [AddrW-1:0]    texel_address;
    logic [ColourW-1:0]  texel_value;
    logic [XW-1:0]       span_start_x;
    logic [XW-1:0]       span_end_x;
    logic [CoordInW-1:0] u_start;
    logic [CoordInW-1:0] v_start;
    logic [CoordInW-1:0] u_end;
    logic [CoordInW-1:0] v_end;
  } raster_req_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        calm   = 1'b0;   // no idling at all in the tail of the run
  logic        steady = 1'b0;   // idling off for a stretch
  int unsigned requests_sent = 0;
  int unsigned spans_started = 0;
  int unsigned stall_left    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels_seen;

  atsk_req_if req_if ();
  atsk_pix_if pix_if ();

  affine_texture_span_keyed #(
    .TEX_ROWS (TexRows),
    .MAX_SPAN (MaxSpan)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .pix_o  (pix_if)
  );

  affine_texture_span_keyed_checker #(
    .TEX_ROWS (TexRows),
    .MAX_SPAN (MaxSpan)
  ) pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .pix_i        (pix_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .pixels_o     (pixels_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Texel row or column of band slot i: 0..7 low band, 8..15 high band
  function automatic int unsigned window_line(input int unsigned i);
    return (i < WinSpan) ? i : TexWidth - 2 * WinSpan + i;
  endfunction

  // Coordinate inside the low or high band, now and then at a band edge
  function automatic logic [CoordInW-1:0] random_coord(input bit hi);
    case ($urandom_range(0, 7))
      0:       return hi ? HiMin : '0;
      1:       return hi ? CoordMax : LoMax;
      default: return (hi ? HiMin : CoordInW'(0))
                      + CoordInW'($urandom_range(0, (WinSpan << 16) - 1));
    endcase
  endfunction

  // Every field random, so unused fields carry noise; both ends of u share
  // a band, as do both ends of v
  function automatic raster_req_t random_request();
    raster_req_t r;
    bit          hu;
    bit          hv;
    hu              = 1'($urandom_range(0, 1));
    hv              = 1'($urandom_range(0, 1));
    r.kind          = kind_e'($urandom_range(0, 3));
    r.texel_address = AddrW'($urandom());
    r.texel_value   = ColourW'($urandom());
    r.span_start_x  = XW'($urandom());
    r.span_end_x    = XW'($urandom());
    r.u_start       = random_coord(hu);
    r.v_start       = random_coord(hv);
    r.u_end         = random_coord(hu);
    r.v_end         = random_coord(hv);
    return r;
  endfunction

  function automatic raster_req_t make_write(input int unsigned addr,
                                             input logic [ColourW-1:0] value);
    raster_req_t r;
    r               = random_request();
    r.kind          = KIND_WRITE;
    r.texel_address = AddrW'(addr);
    r.texel_value   = value;
    return r;
  endfunction

  function automatic raster_req_t make_start(input int unsigned sx, input int unsigned ex,
                                             input logic [CoordInW-1:0] us,
                                             input logic [CoordInW-1:0] vs,
                                             input logic [CoordInW-1:0] ue,
                                             input logic [CoordInW-1:0] ve);
    raster_req_t r;
    r              = random_request();
    r.kind         = KIND_START;
    r.span_start_x = XW'(sx);
    r.span_end_x   = XW'(ex);
    r.u_start      = us;
    r.v_start      = vs;
    r.u_end        = ue;
    r.v_end        = ve;
    return r;
  endfunction

  // Span with random coordinates, each axis kept inside one band
  function automatic raster_req_t make_span(input int unsigned sx, input int unsigned ex);
    bit hu;
    bit hv;
    hu = 1'($urandom_range(0, 1));
    hv = 1'($urandom_range(0, 1));
    return make_start(sx, ex, random_coord(hu), random_coord(hv),
                      random_coord(hu), random_coord(hv));
  endfunction

  function automatic raster_req_t make_step();
    raster_req_t r;
    r      = random_request();
    r.kind = KIND_STEP;
    return r;
  endfunction

  function automatic logic [ColourW-1:0] random_colour();
    return ($urandom_range(0, 7) == 0) ? MaskColour : ColourW'($urandom());
  endfunction

  // Offer one request, maybe after an idle burst, and wait for its handshake
  task automatic send_req(input raster_req_t r);
    if (!(calm || steady) && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.kind          <= r.kind;
    req_if.texel_address <= r.texel_address;
    req_if.texel_value   <= r.texel_value;
    req_if.span_start_x  <= r.span_start_x;
    req_if.span_end_x    <= r.span_end_x;
    req_if.u_start       <= r.u_start;
    req_if.v_start       <= r.v_start;
    req_if.u_end         <= r.u_end;
    req_if.v_end         <= r.v_end;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
    if (r.kind == KIND_START) spans_started++;
  endtask

  // Pixel side back-pressure in random stall bursts
  initial begin
    pix_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        pix_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        pix_if.ready <= 1'b0;
      end else if (!(calm || steady) && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no handshake on either channel
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int unsigned row;
    int unsigned col;
    int unsigned k;
    int unsigned len;
    int unsigned sx;
    int unsigned steps;
    int unsigned pick;
    int unsigned random_base;
    int unsigned random_sent;
    int unsigned next_mood;
    bit          full_span_done;

    req_if.valid         <= 1'b0;
    req_if.kind          <= KIND_NONE;
    req_if.texel_address <= '0;
    req_if.texel_value   <= '0;
    req_if.span_start_x  <= '0;
    req_if.span_end_x    <= '0;
    req_if.u_start       <= '0;
    req_if.v_start       <= '0;
    req_if.u_end         <= '0;
    req_if.v_end         <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Preload the four corner blocks, the only texels a span can sample
    for (row = 0; row < 2 * WinSpan; row++) begin
      for (col = 0; col < 2 * WinSpan; col++) begin
        send_req(make_write(window_line(row) * TexWidth + window_line(col),
                            random_colour()));
      end
    end

    // Directed: corner texels, idle steps, empty spans, extreme coordinates
    send_req(make_write(0, MaskColour));
    send_req(make_write(StoreSize - 1, 8'd0));
    send_req(make_write(TexWidth - 1, 8'd128));
    send_req(make_step());                      // no span yet
    send_req(make_start(100, 99, '0, '0, CoordMax, CoordMax));
    send_req(make_step());                      // span of zero pixels
    begin : unused_kind
      raster_req_t r;
      r      = random_request();
      r.kind = KIND_NONE;
      send_req(r);
    end
    send_req(make_start(2047, 0, CoordMax, CoordMax, '0, '0));
    send_req(make_start(0, 0, '0, '0, CoordMax, '0));
    send_req(make_step());                      // single pixel, masked texel
    send_req(make_step());
    send_req(make_start(2040, 2047, CoordMax, CoordMax, HiMin, HiMin));
    for (k = 0; k < 9; k++) send_req(make_step()); // one step past the end

    // Random: mostly whole spans with random content, plus noise
    random_base    = requests_sent;
    random_sent    = 0;
    next_mood      = 0;
    full_span_done = 1'b0;
    while (random_sent < RandomItems) begin
      if (random_sent >= next_mood) begin
        steady    = ($urandom_range(0, 3) == 0);
        next_mood = next_mood + 100;
      end
      calm = (random_sent > RandomItems * 7 / 8);
      pick = $urandom_range(0, 99);
      if (!full_span_done && random_sent >= RandomItems / 2) begin
        // one span across the whole screen, drawn only at its start
        send_req(make_span(0, 2047));
        for (k = 0; k < 16; k++) send_req(make_step());
        full_span_done = 1'b1;
      end else if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
        sx  = $urandom_range(0, 2048 - len);
        send_req(make_span(sx, sx + len - 1));
        case ($urandom_range(0, 9))
          0:       steps = $urandom_range(0, len - 1);     // cut short
          1:       steps = len + $urandom_range(1, 3);     // run past the end
          default: steps = len;
        endcase
        for (k = 0; k < steps; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_req(make_write($urandom_range(0, StoreSize - 1), random_colour()));
          end
          send_req(make_step());
        end
      end else if (pick < 80) begin
        send_req(make_write($urandom_range(0, StoreSize - 1), random_colour()));
      end else if (pick < 88) begin
        sx = $urandom_range(1, 2047);
        send_req(make_span(sx, $urandom_range(0, sx - 1)));
        repeat ($urandom_range(1, 2)) send_req(make_step());
      end else if (pick < 94) begin
        send_req(make_step());
      end else if (pick < 97) begin
        begin : noise_none
          raster_req_t r;
          r      = random_request();
          r.kind = KIND_NONE;
          send_req(r);
        end
      end else begin
        begin : noise_start
          raster_req_t r;
          r      = random_request();
          r.kind = KIND_START;
          send_req(r);
        end
      end
      random_sent = requests_sent - random_base;
    end
    req_if.valid <= 1'b0;

    // Drain: every pixel back, then allow for a divide still in flight
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests sent, %0d span starts, %0d pixels compared",
             requests_sent, spans_started, pixels_seen);
    $display("corner texture blocks, empty and edge spans, a full-width span start,"
             + " random idling and back-pressure");
    if (pending != 0) $error("%0d expected pixels never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule : affine_texture_span_keyed_tb
